[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on the same edge, inactive while in reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked on the following edge, inactive while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication checked on the following edge, also across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/ahcpf_pkg.sv]
// ----------------------------------------------------------------------------
// ahcpf_pkg
// Shared constants, job type and helpers for the SOH/EOT framer.
// ----------------------------------------------------------------------------
package ahcpf_pkg;

  localparam logic [7:0] CH_SOH   = 8'h01;
  localparam logic [7:0] CH_PROTO = 8'h4E;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_EOT   = 8'h04;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // One classified payload word, everything the back end needs to emit it.
  typedef struct packed {
    logic       hdr;   // frame opens with this word
    logic       last;  // frame closes with this word
    logic [7:0] data;  // payload after comma mapping
    logic [7:0] sess;  // session digit, ASCII
    logic [7:0] chk;   // checksum, valid when last
  } job_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib <= 4'd9) begin
      return 8'h30 + wide;
    end
    return 8'h37 + wide;  // 'A' - 10
  endfunction

endpackage

[sv/ahcpf_if.sv]
// ----------------------------------------------------------------------------
// ahcpf_in_if / ahcpf_out_if
// Valid/ready channels for payload words and framed words.
// ----------------------------------------------------------------------------
interface ahcpf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       payload_last;

  modport source (output valid, output payload_byte, output payload_last, input ready);
  modport sink   (input valid, input payload_byte, input payload_last, output ready);
endinterface

interface ahcpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       run_end;

  modport source (output valid, output out_byte, output frame_end, output run_end,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_end, input run_end,
                  output ready);
endinterface

[sv/ahcpf_front.sv]
// ----------------------------------------------------------------------------
// ahcpf_front
// Accepts payload words, maps commas, tracks frame state and checksum.
// ----------------------------------------------------------------------------
module ahcpf_front (
  input  logic              clk,
  input  logic              rst_n,
  ahcpf_in_if.sink          in_ch,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  input  logic              q_full,
  output logic              push,
  output ahcpf_pkg::job_t   push_job
);

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [3:0] session_r, session_nxt;

  logic [7:0] sess_dig;
  logic [7:0] data_m;
  logic [7:0] base;
  logic [7:0] total;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  assign sess_dig = ahcpf_pkg::hex_digit(session_r);
  assign data_m   = (in_ch.payload_byte == ahcpf_pkg::CH_COMMA) ? ahcpf_pkg::CH_TAB
                                                                  : in_ch.payload_byte;
  // Sum restarts with 'N' plus session digit on a new frame.
  assign base     = in_frame_r ? sum_r : (ahcpf_pkg::CH_PROTO + sess_dig);
  assign total    = base + data_m;

  always_comb begin
    push_job.hdr  = !in_frame_r;
    push_job.last = in_ch.payload_last;
    push_job.data = data_m;
    push_job.sess = sess_dig;
    push_job.chk  = 8'd0 - total;
  end

  always_comb begin
    in_frame_nxt = in_frame_r;
    sum_nxt      = sum_r;
    session_nxt  = cfg_we ? cfg_wdata : session_r;
    if (push) begin
      in_frame_nxt = !in_ch.payload_last;
      sum_nxt      = in_ch.payload_last ? 8'd0 : total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      sum_r      <= 8'd0;
      session_r  <= 4'd0;
    end else begin
      in_frame_r <= in_frame_nxt;
      sum_r      <= sum_nxt;
      session_r  <= session_nxt;
    end
  end

endmodule

[sv/ahcpf_queue.sv]
// ----------------------------------------------------------------------------
// ahcpf_queue
// Small FIFO of classified jobs between front and back end.
// ----------------------------------------------------------------------------
module ahcpf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ahcpf_pkg::job_t   push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ahcpf_pkg::job_t   head_job
);

  ahcpf_pkg::job_t                   mem_r [ahcpf_pkg::QDEPTH];
  logic [ahcpf_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [ahcpf_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [ahcpf_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;

  assign full       = (cnt_r == ahcpf_pkg::QCNT_W'(ahcpf_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[sv/ahcpf_back.sv]
// ----------------------------------------------------------------------------
// ahcpf_back
// Expands each job into header, payload and trailer words.
// ----------------------------------------------------------------------------
module ahcpf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  ahcpf_pkg::job_t   head_job,
  output logic              pop,
  ahcpf_out_if.source       out_ch
);

  typedef enum logic [6:0] {
    PH_SOH  = 7'b0000001,
    PH_PROT = 7'b0000010,
    PH_SESS = 7'b0000100,
    PH_DATA = 7'b0001000,
    PH_CHKH = 7'b0010000,
    PH_CHKL = 7'b0100000,
    PH_EOT  = 7'b1000000
  } phase_t;

  phase_t     phase_r, phase_nxt, cur, step;
  logic       mid_r, mid_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       frame_end_r, frame_end_nxt;
  logic       run_end_r, run_end_nxt;

  logic       load;
  logic       is_end;
  logic [7:0] cur_byte;

  assign load = !out_valid_r || out_ch.ready;
  assign cur  = mid_r ? phase_r : (head_job.hdr ? PH_SOH : PH_DATA);

  always_comb begin
    cur_byte = head_job.data;
    step     = PH_DATA;
    unique case (cur)
      PH_SOH:  begin cur_byte = ahcpf_pkg::CH_SOH;   step = PH_PROT; end
      PH_PROT: begin cur_byte = ahcpf_pkg::CH_PROTO; step = PH_SESS; end
      PH_SESS: begin cur_byte = head_job.sess;       step = PH_DATA; end
      PH_DATA: begin cur_byte = head_job.data;       step = PH_CHKH; end
      PH_CHKH: begin
        cur_byte = ahcpf_pkg::hex_digit(head_job.chk[7:4]);
        step     = PH_CHKL;
      end
      PH_CHKL: begin
        cur_byte = ahcpf_pkg::hex_digit(head_job.chk[3:0]);
        step     = PH_EOT;
      end
      PH_EOT:  begin cur_byte = ahcpf_pkg::CH_EOT;   step = PH_SOH;  end
      default: begin cur_byte = head_job.data;       step = PH_DATA; end
    endcase
  end

  assign is_end = ((cur == PH_DATA) && !head_job.last) || (cur == PH_EOT);
  assign pop    = load && head_valid && is_end;

  always_comb begin
    phase_nxt     = phase_r;
    mid_nxt       = mid_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    frame_end_nxt = frame_end_r;
    run_end_nxt   = run_end_r;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        out_byte_nxt  = cur_byte;
        frame_end_nxt = (cur == PH_EOT);
        run_end_nxt   = is_end;
        mid_nxt       = !is_end;
        phase_nxt     = step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SOH;
      mid_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      mid_r       <= mid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    frame_end_r <= frame_end_nxt;
    run_end_r   <= run_end_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.frame_end = frame_end_r;
  assign out_ch.run_end   = run_end_r;

endmodule

[sv/ascii_hex_checksum_packet_framer_top.sv]
// ----------------------------------------------------------------------------
// ascii_hex_checksum_packet_framer_top
// SOH/EOT packet framer with a two-digit ASCII hex additive checksum.
// ----------------------------------------------------------------------------
// The first framed word of a payload word passes the job queue, then the output register.
// One framed word per cycle unless out_ch.ready stalls the single output register;
//   a mid-frame word yields 1 word, a frame's first word 3 more, its last 3 more.
// Input accepts every cycle while the 4-deep job queue has room.
// Reset (rst_n low, synchronous) closes any open frame, clears the checksum,
//   empties the queue and output, and sets the session nibble to 0.
// ----------------------------------------------------------------------------
module ascii_hex_checksum_packet_framer_top (
  input  logic        clk,
  input  logic        rst_n,
  ahcpf_in_if.sink    in_ch,
  ahcpf_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata
);

  // Front end: decides header/trailer, maps commas, keeps the running sum
  // and the session register. Each accepted word becomes one job.
  logic            push;
  ahcpf_pkg::job_t push_job;
  logic            q_full;

  // Back end side of the queue.
  logic            pop;
  logic            head_valid;
  ahcpf_pkg::job_t head_job;

  ahcpf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Queue decouples acceptance from the 1..7 word expansion of each job,
  // so header/trailer bursts do not stall the input immediately.
  ahcpf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_job  (head_job)
  );

  // Back end: walks SOH, 'N', session, data, checksum hi/lo, EOT as needed,
  // one word per cycle into the output register unless stalled; pops on the job's last word.
  ahcpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_job  (head_job),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

[sv/ahcpf_checker.sv]
// ----------------------------------------------------------------------------
// ahcpf_checker
// Port-level checks for the framer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ahcpf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       frame_end,
  input logic       run_end
);

  // stalled word holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte))
  // EOT always closes the run of its input word
  `ASSERT_SAME(a_end_run, clk, rst_n, out_valid && frame_end, run_end)
  // frame end marks EOT only
  `ASSERT_SAME(a_end_eot, clk, rst_n, out_valid && frame_end, out_byte == ahcpf_pkg::CH_EOT)
  // output empty right after reset
  `ASSERT_NEXT_ALWAYS(a_rst_idle, clk, !rst_n, !out_valid)

endmodule

bind ascii_hex_checksum_packet_framer_top ahcpf_checker u_ahcpf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_byte (out_ch.out_byte),
  .frame_end(out_ch.frame_end),
  .run_end  (out_ch.run_end)
);
